// ===== hdl/rcs_pkg.sv =====
// Shared types, opcodes and result codes for the integer core.
package rcs_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG,
    ST_IDX,
    ST_MOD,
    ST_DIV,
    ST_MEMR,
    ST_FIN
  } state_e;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_HALT    = 2'd1;
  localparam logic [1:0] STAT_DIV0    = 2'd2;
  localparam logic [1:0] STAT_ILLEGAL = 2'd3;

  localparam logic [31:0] PC_RESET    = 32'h0040_0000;
  localparam logic [31:0] HALT_CODE   = 32'd10;
  localparam logic [4:0]  REG_LINK    = 5'd31;
  localparam logic [4:0]  REG_SYSARG  = 5'd2;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;
  localparam logic [5:0] FN_SLTU    = 6'h2B;

  localparam logic [4:0] RI_BLTZ    = 5'h00;
  localparam logic [4:0] RI_BGEZ    = 5'h01;
  localparam logic [4:0] RI_BLTZAL  = 5'h10;
  localparam logic [4:0] RI_BGEZAL  = 5'h11;

  typedef struct packed {
    logic        preload;
    logic        stopped;
    logic [31:0] pc;
    logic [31:0] ins;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] addr;
    logic [31:0] word;
    logic [63:0] prod;
    logic [31:0] quot;
    logic [31:0] rem;
    logic [31:0] pdata;
  } exec_in_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [1:0]  status;
    logic        reg_written;
    logic [4:0]  dest_reg;
    logic [31:0] dest_value;
    logic        mem_written;
    logic [31:0] mem_address;
    logic [31:0] mem_value;
    logic [31:0] hi;
    logic [31:0] lo;
    logic        stop;
  } exec_out_t;

  function automatic logic is_mem_op(input logic [5:0] op);
    return (op == OP_LB) || (op == OP_LH) || (op == OP_LW) || (op == OP_LBU) ||
           (op == OP_LHU) || (op == OP_SB) || (op == OP_SH) || (op == OP_SW);
  endfunction

endpackage

// ===== hdl/rcs_req_if.sv =====
// Request channel: one execute or preload request.
interface rcs_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] instruction;
  logic [31:0] preload_address;
  logic [31:0] preload_data;

  modport source (output valid, operation, instruction, preload_address, preload_data,
                  input ready);
  modport sink   (input valid, operation, instruction, preload_address, preload_data,
                  output ready);
endinterface

// ===== hdl/rcs_rsp_if.sv =====
// Response channel: one result per request.
interface rcs_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic [1:0]  status;
  logic        reg_written;
  logic [4:0]  dest_reg;
  logic [31:0] dest_value;
  logic        mem_written;
  logic [31:0] mem_address;
  logic [31:0] mem_value;

  modport source (output valid, next_pc, status, reg_written, dest_reg, dest_value,
                  mem_written, mem_address, mem_value, input ready);
  modport sink   (input valid, next_pc, status, reg_written, dest_reg, dest_value,
                  mem_written, mem_address, mem_value, output ready);
endinterface

// ===== hdl/risc_integer_core_step.sv =====
// States from accept to response valid: ALU, branch, jump and MULT/MULTU ST_REG, ST_FIN;
// loads, stores and preloads ST_REG, ST_MEMR, ST_FIN, with ST_IDX, ST_MOD before ST_MEMR
// for non-power-of-two DATA_WORDS (word index by reciprocal multiply); DIV/DIVU ST_REG,
// ST_DIV, ST_FIN (one quotient bit per cycle). One request in flight; the next is
// accepted in the cycle after commit, and commit waits while the response is stalled.
// Reset: PC 0x00400000, registers/HI/LO zero (valid bits), not stopped; no memory clear.
module risc_integer_core_step #(
  parameter int DATA_WORDS = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [31:0]     cfg_wdata_i,
  rcs_req_if.sink         req_i,
  rcs_rsp_if.source       rsp_o
);

  localparam int  AW   = $clog2(DATA_WORDS);
  localparam bit  POW2 = (DATA_WORDS & (DATA_WORDS - 1)) == 0;
  localparam logic [31:0] DWORDS = 32'(DATA_WORDS);
  // floor(2^32 / DATA_WORDS): quotient estimate is exact or one low
  localparam logic [31:0] RECIP  = 32'((64'd1 << 32) / DATA_WORDS);

  rcs_pkg::state_e state_q, state_d;

  logic [31:0] pc_q;
  logic [31:0] hi_q;
  logic [31:0] lo_q;
  logic        stopped_q;
  logic [31:0] rv_q;

  logic        op_q;
  logic [31:0] ins_q;
  logic [31:0] paddr_q;
  logic [31:0] pdata_q;
  logic [4:0]  ra_q;
  logic [4:0]  rb_q;
  logic [31:0] a_q;
  logic [31:0] b_q;
  logic [31:0] addr_q;
  logic [63:0] prod_q;
  logic [AW-1:0] idx_q;
  logic [31:0] modq_q;

  logic        rsp_valid_q;
  rcs_pkg::exec_out_t rsp_q;

  logic        accept;
  logic        commit;
  logic [4:0]  raddr_a;
  logic [4:0]  raddr_b;
  logic [31:0] rf_a;
  logic [31:0] rf_b;
  logic [31:0] a_rd;
  logic [31:0] b_rd;
  logic [31:0] addr_calc;
  logic        sgn;
  logic [63:0] prod_calc;
  logic [5:0]  ins_op;
  logic [5:0]  ins_fn;
  logic        is_div;
  logic        is_mult;
  logic        needs_mem;
  logic [31:0] dmem_word;

  logic [31:0] mod_n;
  logic [63:0] mod_prod;
  logic [31:0] mod_back;
  logic [31:0] mod_r;
  logic [31:0] mod_fix;

  logic        div_start;
  logic [31:0] div_n;
  logic [31:0] div_d;
  logic        div_done;
  logic [31:0] div_q;
  logic [31:0] div_r;

  rcs_pkg::exec_in_t  ex_in;
  rcs_pkg::exec_out_t ex_out;

  assign accept  = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == rcs_pkg::ST_IDLE);
  assign commit  = (state_q == rcs_pkg::ST_FIN) && (!rsp_valid_q || rsp_o.ready);

  // SYSCALL reads register 2 through port A
  assign raddr_a = ((req_i.instruction[31:26] == rcs_pkg::OP_SPECIAL) &&
                    (req_i.instruction[5:0] == rcs_pkg::FN_SYSCALL))
                   ? rcs_pkg::REG_SYSARG : req_i.instruction[25:21];
  assign raddr_b = req_i.instruction[20:16];

  rcs_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (commit && ex_out.reg_written),
    .waddr_i (ex_out.dest_reg),
    .wdata_i (ex_out.dest_value),
    .raddr_i (raddr_a),
    .rdata_o (rf_a)
  );

  rcs_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (commit && ex_out.reg_written),
    .waddr_i (ex_out.dest_reg),
    .wdata_i (ex_out.dest_value),
    .raddr_i (raddr_b),
    .rdata_o (rf_b)
  );

  rcs_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
    .clk_i   (clk_i),
    .we_i    (commit && ex_out.mem_written),
    .waddr_i (idx_q),
    .wdata_i (ex_out.mem_value),
    .raddr_i (idx_q),
    .rdata_o (dmem_word)
  );

  // never-written registers read as zero
  assign a_rd      = rv_q[ra_q] ? rf_a : '0;
  assign b_rd      = rv_q[rb_q] ? rf_b : '0;
  assign ins_op    = ins_q[31:26];
  assign ins_fn    = ins_q[5:0];
  assign addr_calc = op_q ? paddr_q : a_rd + {{16{ins_q[15]}}, ins_q[15:0]};
  assign is_mult   = (ins_op == rcs_pkg::OP_SPECIAL) &&
                     ((ins_fn == rcs_pkg::FN_MULT) || (ins_fn == rcs_pkg::FN_MULTU));
  assign is_div    = (ins_op == rcs_pkg::OP_SPECIAL) &&
                     ((ins_fn == rcs_pkg::FN_DIV) || (ins_fn == rcs_pkg::FN_DIVU));
  assign needs_mem = op_q || (!stopped_q && rcs_pkg::is_mem_op(ins_op));
  assign sgn       = (ins_fn == rcs_pkg::FN_MULT) || (ins_fn == rcs_pkg::FN_DIV);
  assign prod_calc = 64'($signed({sgn & a_rd[31], a_rd}) * $signed({sgn & b_rd[31], b_rd}));

  // word index mod DATA_WORDS: multiply by reciprocal, then one correction step
  assign mod_n    = {2'b00, addr_q[31:2]};
  assign mod_prod = {32'b0, mod_n} * {32'b0, RECIP};
  assign mod_back = modq_q * DWORDS;
  assign mod_r    = mod_n - mod_back;
  assign mod_fix  = (mod_r >= DWORDS) ? (mod_r - DWORDS) : mod_r;

  always_comb begin
    div_start = 1'b0;
    div_n     = (sgn && a_rd[31]) ? -a_rd : a_rd;
    div_d     = (sgn && b_rd[31]) ? -b_rd : b_rd;
    if ((state_q == rcs_pkg::ST_REG) && !needs_mem && !stopped_q && is_div &&
        (b_rd != '0)) begin
      div_start = 1'b1;
    end
  end

  rcs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  always_comb begin
    ex_in.preload = op_q;
    ex_in.stopped = stopped_q;
    ex_in.pc      = pc_q;
    ex_in.ins     = ins_q;
    ex_in.a       = a_q;
    ex_in.b       = b_q;
    ex_in.hi      = hi_q;
    ex_in.lo      = lo_q;
    ex_in.addr    = addr_q;
    ex_in.word    = dmem_word;
    ex_in.prod    = prod_q;
    ex_in.quot    = div_q;
    ex_in.rem     = div_r;
    ex_in.pdata   = pdata_q;
  end

  rcs_exec u_exec (
    .ex_i (ex_in),
    .ex_o (ex_out)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rcs_pkg::ST_IDLE: if (accept) state_d = rcs_pkg::ST_REG;
      rcs_pkg::ST_REG: begin
        priority if (needs_mem) begin
          state_d = POW2 ? rcs_pkg::ST_MEMR : rcs_pkg::ST_IDX;
        end else if (div_start) begin
          state_d = rcs_pkg::ST_DIV;
        end else begin
          state_d = rcs_pkg::ST_FIN;
        end
      end
      rcs_pkg::ST_IDX:  state_d = rcs_pkg::ST_MOD;
      rcs_pkg::ST_MOD:  state_d = rcs_pkg::ST_MEMR;
      rcs_pkg::ST_DIV:  if (div_done) state_d = rcs_pkg::ST_FIN;
      rcs_pkg::ST_MEMR: state_d = rcs_pkg::ST_FIN;
      rcs_pkg::ST_FIN:  if (commit) state_d = rcs_pkg::ST_IDLE;
      default:          state_d = rcs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rcs_pkg::ST_IDLE;
      pc_q        <= rcs_pkg::PC_RESET;
      hi_q        <= '0;
      lo_q        <= '0;
      stopped_q   <= 1'b0;
      rv_q        <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        pc_q <= cfg_wdata_i;
      end
      if (commit) begin
        if (!cfg_we_i) begin
          pc_q <= ex_out.next_pc;
        end
        hi_q      <= ex_out.hi;
        lo_q      <= ex_out.lo;
        stopped_q <= ex_out.stop;
        if (ex_out.reg_written) begin
          rv_q[ex_out.dest_reg] <= 1'b1;
        end
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= req_i.operation;
      ins_q   <= req_i.instruction;
      paddr_q <= req_i.preload_address;
      pdata_q <= req_i.preload_data;
      ra_q    <= raddr_a;
      rb_q    <= raddr_b;
    end
    if (state_q == rcs_pkg::ST_REG) begin
      a_q    <= a_rd;
      b_q    <= b_rd;
      addr_q <= addr_calc;
      idx_q  <= addr_calc[AW+1:2];
      if (is_mult) begin
        prod_q <= prod_calc;
      end
    end
    if (state_q == rcs_pkg::ST_IDX) begin
      modq_q <= mod_prod[63:32];
    end
    if (state_q == rcs_pkg::ST_MOD) begin
      idx_q <= mod_fix[AW-1:0];
    end
    if (commit) begin
      rsp_q <= ex_out;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.next_pc     = rsp_q.next_pc;
  assign rsp_o.status      = rsp_q.status;
  assign rsp_o.reg_written = rsp_q.reg_written;
  assign rsp_o.dest_reg    = rsp_q.dest_reg;
  assign rsp_o.dest_value  = rsp_q.dest_value;
  assign rsp_o.mem_written = rsp_q.mem_written;
  assign rsp_o.mem_address = rsp_q.mem_address;
  assign rsp_o.mem_value   = rsp_q.mem_value;

endmodule

// ===== hdl/rcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/rcs_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module rcs_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [31:0] rem_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [31:0] q_q;
  logic [31:0] r_q;
  logic [31:0] d_q;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  assign trial = {r_q, q_q[31]};
  assign diff  = trial - {1'b0, d_q};
  assign ge    = ~diff[32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q) begin
      r_q <= ge ? diff[31:0] : trial[31:0];
      q_q <= {q_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

// ===== hdl/rcs_exec.sv =====
// Instruction execute: result, next PC, register and memory writes.
module rcs_exec (
  input  rcs_pkg::exec_in_t  ex_i,
  output rcs_pkg::exec_out_t ex_o
);

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [31:0] imm;
  logic [31:0] simm;
  logic [31:0] br_tgt;
  logic [31:0] link;
  logic [31:0] j_tgt;
  logic [4:0]  bsh;
  logic [31:0] wsh;
  logic [15:0] half;
  logic [31:0] bmask;
  logic [31:0] q_fix;
  logic [31:0] r_fix;
  logic        a_lt0;
  logic [31:0] npc;
  logic [1:0]  st;
  logic [1:0]  err;
  logic        rw;
  logic [4:0]  rdst;
  logic [31:0] rval;
  logic        mw;
  logic [31:0] mval;
  logic [31:0] nhi;
  logic [31:0] nlo;

  assign op     = ex_i.ins[31:26];
  assign rt     = ex_i.ins[20:16];
  assign rd     = ex_i.ins[15:11];
  assign sh     = ex_i.ins[10:6];
  assign fn     = ex_i.ins[5:0];
  assign imm    = {16'b0, ex_i.ins[15:0]};
  assign simm   = {{16{ex_i.ins[15]}}, ex_i.ins[15:0]};
  assign br_tgt = ex_i.pc + {simm[29:0], 2'b00};
  assign link   = ex_i.pc + 32'd4;
  assign j_tgt  = {ex_i.pc[31:28], ex_i.ins[25:0], 2'b00};
  assign bsh    = {ex_i.addr[1:0], 3'b000};
  assign wsh    = ex_i.word >> bsh;
  assign half   = ex_i.addr[1] ? ex_i.word[31:16] : ex_i.word[15:0];
  assign bmask  = 32'h0000_00FF << bsh;
  assign a_lt0  = ex_i.a[31];
  // divider works on magnitudes; fix signs for DIV
  assign q_fix  = ((fn == rcs_pkg::FN_DIV) && (ex_i.a[31] ^ ex_i.b[31])) ? -ex_i.quot
                                                                          : ex_i.quot;
  assign r_fix  = ((fn == rcs_pkg::FN_DIV) && ex_i.a[31]) ? -ex_i.rem : ex_i.rem;

  always_comb begin
    npc  = link;
    st   = rcs_pkg::STAT_OK;
    err  = rcs_pkg::STAT_OK;
    rw   = 1'b0;
    rdst = rt;
    rval = '0;
    mw   = 1'b0;
    mval = '0;
    nhi  = ex_i.hi;
    nlo  = ex_i.lo;

    unique case (op)
      rcs_pkg::OP_SPECIAL: begin
        rdst = rd;
        unique case (fn)
          rcs_pkg::FN_SLL:  begin rw = 1'b1; rval = ex_i.b << sh; end
          rcs_pkg::FN_SRL:  begin rw = 1'b1; rval = ex_i.b >> sh; end
          rcs_pkg::FN_SRA:  begin rw = 1'b1; rval = 32'($signed(ex_i.b) >>> sh); end
          rcs_pkg::FN_SLLV: begin rw = 1'b1; rval = ex_i.b << ex_i.a[4:0]; end
          rcs_pkg::FN_SRLV: begin rw = 1'b1; rval = ex_i.b >> ex_i.a[4:0]; end
          rcs_pkg::FN_SRAV: begin
            rw = 1'b1;
            rval = 32'($signed(ex_i.b) >>> ex_i.a[4:0]);
          end
          rcs_pkg::FN_JR:   npc = ex_i.a;
          rcs_pkg::FN_JALR: begin
            rw   = 1'b1;
            rdst = (rd == 5'd0) ? rcs_pkg::REG_LINK : rd;
            rval = link;
            npc  = ex_i.a;
          end
          rcs_pkg::FN_ADD, rcs_pkg::FN_ADDU: begin rw = 1'b1; rval = ex_i.a + ex_i.b; end
          rcs_pkg::FN_SUB, rcs_pkg::FN_SUBU: begin rw = 1'b1; rval = ex_i.a - ex_i.b; end
          rcs_pkg::FN_AND:  begin rw = 1'b1; rval = ex_i.a & ex_i.b; end
          rcs_pkg::FN_OR:   begin rw = 1'b1; rval = ex_i.a | ex_i.b; end
          rcs_pkg::FN_XOR:  begin rw = 1'b1; rval = ex_i.a ^ ex_i.b; end
          rcs_pkg::FN_NOR:  begin rw = 1'b1; rval = ~(ex_i.a | ex_i.b); end
          rcs_pkg::FN_SLT:  begin
            rw = 1'b1;
            rval = {31'b0, $signed(ex_i.a) < $signed(ex_i.b)};
          end
          rcs_pkg::FN_SLTU: begin rw = 1'b1; rval = {31'b0, ex_i.a < ex_i.b}; end
          rcs_pkg::FN_MULT, rcs_pkg::FN_MULTU: begin
            nlo = ex_i.prod[31:0];
            nhi = ex_i.prod[63:32];
          end
          rcs_pkg::FN_DIV, rcs_pkg::FN_DIVU: begin
            if (ex_i.b == '0) begin
              err = rcs_pkg::STAT_DIV0;
            end else begin
              nlo = q_fix;
              nhi = r_fix;
            end
          end
          rcs_pkg::FN_MFHI: begin rw = 1'b1; rval = ex_i.hi; end
          rcs_pkg::FN_MFLO: begin rw = 1'b1; rval = ex_i.lo; end
          rcs_pkg::FN_MTHI: nhi = ex_i.a;
          rcs_pkg::FN_MTLO: nlo = ex_i.a;
          // operand a holds register 2 for this one
          rcs_pkg::FN_SYSCALL: begin
            if (ex_i.a == rcs_pkg::HALT_CODE) begin
              st = rcs_pkg::STAT_HALT;
            end
          end
          default: err = rcs_pkg::STAT_ILLEGAL;
        endcase
      end
      rcs_pkg::OP_REGIMM: begin
        unique case (rt)
          rcs_pkg::RI_BLTZ: if (a_lt0) npc = br_tgt;
          rcs_pkg::RI_BGEZ: if (!a_lt0) npc = br_tgt;
          rcs_pkg::RI_BLTZAL: begin
            rw = 1'b1; rdst = rcs_pkg::REG_LINK; rval = link;
            if (a_lt0) npc = br_tgt;
          end
          rcs_pkg::RI_BGEZAL: begin
            rw = 1'b1; rdst = rcs_pkg::REG_LINK; rval = link;
            if (!a_lt0) npc = br_tgt;
          end
          default: err = rcs_pkg::STAT_ILLEGAL;
        endcase
      end
      rcs_pkg::OP_J:   npc = j_tgt;
      rcs_pkg::OP_JAL: begin
        rw = 1'b1; rdst = rcs_pkg::REG_LINK; rval = link; npc = j_tgt;
      end
      rcs_pkg::OP_BEQ:  if (ex_i.a == ex_i.b) npc = br_tgt;
      rcs_pkg::OP_BNE:  if (ex_i.a != ex_i.b) npc = br_tgt;
      rcs_pkg::OP_BLEZ: if ((ex_i.a == '0) || a_lt0) npc = br_tgt;
      rcs_pkg::OP_BGTZ: if ((ex_i.a != '0) && !a_lt0) npc = br_tgt;
      rcs_pkg::OP_ADDI, rcs_pkg::OP_ADDIU: begin rw = 1'b1; rval = ex_i.a + simm; end
      rcs_pkg::OP_SLTI:  begin rw = 1'b1; rval = {31'b0, $signed(ex_i.a) < $signed(simm)}; end
      rcs_pkg::OP_SLTIU: begin rw = 1'b1; rval = {31'b0, ex_i.a < imm}; end
      rcs_pkg::OP_ANDI:  begin rw = 1'b1; rval = ex_i.a & imm; end
      rcs_pkg::OP_ORI:   begin rw = 1'b1; rval = ex_i.a | imm; end
      rcs_pkg::OP_XORI:  begin rw = 1'b1; rval = ex_i.a ^ imm; end
      rcs_pkg::OP_LUI:   begin rw = 1'b1; rval = {ex_i.ins[15:0], 16'b0}; end
      rcs_pkg::OP_LB:    begin rw = 1'b1; rval = {{24{wsh[7]}}, wsh[7:0]}; end
      rcs_pkg::OP_LBU:   begin rw = 1'b1; rval = {24'b0, wsh[7:0]}; end
      rcs_pkg::OP_LH:    begin rw = 1'b1; rval = {{16{half[15]}}, half}; end
      rcs_pkg::OP_LHU:   begin rw = 1'b1; rval = {16'b0, half}; end
      rcs_pkg::OP_LW:    begin rw = 1'b1; rval = ex_i.word; end
      rcs_pkg::OP_SB: begin
        mw   = 1'b1;
        mval = (ex_i.word & ~bmask) | ({24'b0, ex_i.b[7:0]} << bsh);
      end
      rcs_pkg::OP_SH: begin
        mw   = 1'b1;
        mval = ex_i.addr[1] ? {ex_i.b[15:0], ex_i.word[15:0]}
                            : {ex_i.word[31:16], ex_i.b[15:0]};
      end
      rcs_pkg::OP_SW: begin mw = 1'b1; mval = ex_i.b; end
      default: err = rcs_pkg::STAT_ILLEGAL;
    endcase

    if (rdst == 5'd0) begin
      rw = 1'b0;
    end

    ex_o.next_pc     = npc;
    ex_o.status      = st;
    ex_o.reg_written = rw;
    ex_o.dest_reg    = rw ? rdst : 5'd0;
    ex_o.dest_value  = rw ? rval : '0;
    ex_o.mem_written = mw;
    ex_o.mem_address = mw ? {ex_i.addr[31:2], 2'b00} : '0;
    ex_o.mem_value   = mw ? mval : '0;
    ex_o.hi          = nhi;
    ex_o.lo          = nlo;
    ex_o.stop        = (st == rcs_pkg::STAT_HALT);

    priority if (ex_i.preload) begin
      ex_o             = '0;
      ex_o.next_pc     = ex_i.pc;
      ex_o.status      = ex_i.stopped ? rcs_pkg::STAT_HALT : rcs_pkg::STAT_OK;
      ex_o.mem_written = 1'b1;
      ex_o.mem_address = {ex_i.addr[31:2], 2'b00};
      ex_o.mem_value   = ex_i.pdata;
      ex_o.hi          = ex_i.hi;
      ex_o.lo          = ex_i.lo;
      ex_o.stop        = ex_i.stopped;
    end else if (ex_i.stopped) begin
      ex_o         = '0;
      ex_o.next_pc = ex_i.pc;
      ex_o.status  = rcs_pkg::STAT_HALT;
      ex_o.hi      = ex_i.hi;
      ex_o.lo      = ex_i.lo;
      ex_o.stop    = 1'b1;
    end else if (err != rcs_pkg::STAT_OK) begin
      ex_o         = '0;
      ex_o.next_pc = ex_i.pc;
      ex_o.status  = err;
      ex_o.hi      = ex_i.hi;
      ex_o.lo      = ex_i.lo;
      ex_o.stop    = 1'b1;
    end else begin
      ex_o.stop = ex_o.stop;
    end
  end

endmodule

// ===== hdl/rcs_chk.sv =====
// Port-level checks for the integer core, bound to the top level.
module rcs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] next_pc_i,
  input logic [1:0]  status_i,
  input logic        reg_written_i,
  input logic [4:0]  dest_reg_i,
  input logic        mem_written_i,
  input logic [31:0] mem_address_i
);

  // one request at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request accepted while another is in flight");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(next_pc_i) &&
                                       $stable(status_i)))
    else $error("stalled response changed");

  a_err_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && ((status_i == rcs_pkg::STAT_DIV0) ||
                     (status_i == rcs_pkg::STAT_ILLEGAL)))
    |-> (!reg_written_i && !mem_written_i))
    else $error("error response reports a write");

  a_no_r0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && reg_written_i) |-> (dest_reg_i != 5'd0))
    else $error("write to register zero reported");

  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && mem_written_i) |-> (mem_address_i[1:0] == 2'b00))
    else $error("unaligned memory write address");

endmodule

bind risc_integer_core_step rcs_chk u_rcs_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .next_pc_i     (rsp_o.next_pc),
  .status_i      (rsp_o.status),
  .reg_written_i (rsp_o.reg_written),
  .dest_reg_i    (rsp_o.dest_reg),
  .mem_written_i (rsp_o.mem_written),
  .mem_address_i (rsp_o.mem_address)
);
